[design/cube_sphere_vertex_generator_assert.svh]
// Assertion macros for the cube-sphere vertex generator.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef CUBE_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define CUBE_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is asserted
`define CSV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cube-sphere vertex generator check failed");
// clocked check, also active during reset
`define CSV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cube-sphere vertex generator reset check failed");
`else
`define CSV_ASSERT(lbl, clk, rst_n, prop)
`define CSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/csv_pkg.sv]
// Shared types, constants and the Q30 multiply for the cube-sphere vertex generator.
// No dependencies.
`timescale 1ns / 1ps
package csv_pkg;
	localparam int IDX_W     = 9;
	localparam int LVL_W     = 4;
	localparam int SPAN_W    = 10;
	localparam int MAX_LEVEL = 8;
	localparam int Q_W       = 31;
	localparam int P_W       = 2 * Q_W;
	localparam int VEC_W     = 16;
	localparam int VEC_MAX   = 32767;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [LVL_W-1:0]        lvl_t;
	typedef logic [Q_W-1:0]          q30_t;
	typedef logic signed [VEC_W-1:0] vec_t;

	localparam lvl_t LVL_RESET = 4'd8;

	localparam q30_t Q30_ONE = 31'd1073741824;
	localparam q30_t PIH     = 31'd1686629713;
	localparam q30_t S3      = 31'd178956971;
	localparam q30_t S5      = 31'd8947849;
	localparam q30_t S7      = 31'd213044;
	localparam q30_t S9      = 31'd2959;
	localparam q30_t C2      = 31'd536870912;
	localparam q30_t C4      = 31'd44739243;
	localparam q30_t C6      = 31'd1491308;
	localparam q30_t C8      = 31'd26631;
	localparam q30_t C10     = 31'd296;

	typedef struct packed {
		logic err;
		logic neg_y;
		logic neg_z;
	} tag_t;

	// rounded Q30 product of magnitudes
	function automatic q30_t qmul(input q30_t a, input q30_t b);
		logic [P_W-1:0] p;
		p = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b} + (P_W'(1) << 29);
		return q30_t'(p >> 30);
	endfunction
endpackage

[design/csv_if.sv]
// Channel interfaces: grid request, vertex result, level configuration write.
// Depends on csv_pkg.
`timescale 1ns / 1ps
interface csv_in_if import csv_pkg::*; ();
	logic valid;
	logic ready;
	idx_t row_index;
	idx_t col_index;
	modport source(output valid, output row_index, output col_index, input ready);
	modport sink(input valid, input row_index, input col_index, output ready);
endinterface

interface csv_out_if import csv_pkg::*; ();
	logic valid;
	logic ready;
	vec_t vec_x;
	vec_t vec_y;
	vec_t vec_z;
	logic index_error;
	modport source(output valid, output vec_x, output vec_y, output vec_z,
		output index_error, input ready);
	modport sink(input valid, input vec_x, input vec_y, input vec_z,
		input index_error, output ready);
endinterface

interface csv_cfg_if import csv_pkg::*; ();
	logic valid;
	logic ready;
	lvl_t subdivision_level;
	modport source(output valid, output subdivision_level, input ready);
	modport sink(input valid, input subdivision_level, output ready);
endinterface

[design/csv_angle.sv]
// Index decode and angle stages: grid offsets, range check, Q30 angle magnitudes.
// Depends on csv_pkg.
`timescale 1ns / 1ps
module csv_angle import csv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  idx_t row,
	input  idx_t col,
	input  lvl_t lvl,
	output logic out_vld,
	output q30_t ang [2],
	output tag_t tag
);
	localparam int MW = IDX_W + Q_W;

	lvl_t              lvl_e;
	logic [SPAN_W-1:0] span;
	idx_t              half;
	logic              neg1, neg2, err;
	idx_t              m1, m2;
	logic [MW-1:0]     p1, p2;

	logic vld_s1, vld_s2;
	idx_t m1_s1, m2_s1, half_s1;
	lvl_t lvl_s1;
	tag_t tag_s1, tag_s2;
	q30_t x1_s2, x2_s2;

	always_comb begin
		if (lvl == '0) begin
			lvl_e = LVL_W'(1);
		end else if (lvl > LVL_W'(MAX_LEVEL)) begin
			lvl_e = LVL_W'(MAX_LEVEL);
		end else begin
			lvl_e = lvl;
		end
		span = SPAN_W'(1) << lvl_e;
		half = idx_t'(span >> 1);
		err  = ({1'b0, row} > span) || ({1'b0, col} > span);
		neg2 = row > half;
		m2   = neg2 ? row - half : half - row;
		neg1 = col < half;
		m1   = neg1 ? half - col : col - half;
	end

	assign p1 = MW'(m1_s1) * MW'(PIH) + MW'(half_s1);
	assign p2 = MW'(m2_s1) * MW'(PIH) + MW'(half_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1   <= m1;
			m2_s1   <= m2;
			half_s1 <= half;
			lvl_s1  <= lvl_e;
			tag_s1  <= '{err: err, neg_y: neg2, neg_z: !neg1};
			x1_s2   <= q30_t'(p1 >> lvl_s1);
			x2_s2   <= q30_t'(p2 >> lvl_s1);
			tag_s2  <= tag_s1;
		end
	end

	assign out_vld = vld_s2;
	assign ang[0]  = x1_s2;
	assign ang[1]  = x2_s2;
	assign tag     = tag_s2;
endmodule

[design/csv_trig.sv]
// Sine and cosine of two Q30 angles by pipelined Horner evaluation.
// Depends on csv_pkg.
`timescale 1ns / 1ps
module csv_trig import csv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  q30_t ang [2],
	input  tag_t tag_in,
	output logic out_vld,
	output q30_t sn [2],
	output q30_t cs [2],
	output tag_t tag_out
);
	localparam int NST = 6;

	q30_t xa_s1 [2], xa_s2 [2], xa_s3 [2], xa_s4 [2], xa_s5 [2];
	q30_t xx_s1 [2], xx_s2 [2], xx_s3 [2], xx_s4 [2], xx_s5 [2];
	q30_t sp_s2 [2], sp_s3 [2], sp_s4 [2], sp_s5 [2];
	q30_t cp_s2 [2], cp_s3 [2], cp_s4 [2], cp_s5 [2];
	q30_t sin_s6 [2], cos_s6 [2];
	logic vld_s [1:NST];
	tag_t tag_s [1:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int k = 2; k <= NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				xa_s1[i]  <= ang[i];
				xx_s1[i]  <= qmul(ang[i], ang[i]);
				xa_s2[i]  <= xa_s1[i];
				xx_s2[i]  <= xx_s1[i];
				sp_s2[i]  <= S7 - qmul(xx_s1[i], S9);
				cp_s2[i]  <= C8 - qmul(xx_s1[i], C10);
				xa_s3[i]  <= xa_s2[i];
				xx_s3[i]  <= xx_s2[i];
				sp_s3[i]  <= S5 - qmul(xx_s2[i], sp_s2[i]);
				cp_s3[i]  <= C6 - qmul(xx_s2[i], cp_s2[i]);
				xa_s4[i]  <= xa_s3[i];
				xx_s4[i]  <= xx_s3[i];
				sp_s4[i]  <= S3 - qmul(xx_s3[i], sp_s3[i]);
				cp_s4[i]  <= C4 - qmul(xx_s3[i], cp_s3[i]);
				xa_s5[i]  <= xa_s4[i];
				xx_s5[i]  <= xx_s4[i];
				sp_s5[i]  <= Q30_ONE - qmul(xx_s4[i], sp_s4[i]);
				cp_s5[i]  <= C2 - qmul(xx_s4[i], cp_s4[i]);
				sin_s6[i] <= qmul(xa_s5[i], sp_s5[i]);
				cos_s6[i] <= Q30_ONE - qmul(xx_s5[i], cp_s5[i]);
			end
			tag_s[1] <= tag_in;
			for (int k = 2; k <= NST; k++) tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_vld = vld_s[NST];
	assign tag_out = tag_s[NST];
	assign sn      = sin_s6;
	assign cs      = cos_s6;
endmodule

[design/csv_norm.sv]
// Direction components, squared norm and a bit-per-stage integer square root.
// Depends on csv_pkg.
`timescale 1ns / 1ps
module csv_norm import csv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  q30_t sn [2],
	input  q30_t cs [2],
	input  tag_t tag_in,
	output logic out_vld,
	output q30_t vec [3],
	output q30_t norm,
	output tag_t tag_out
);
	localparam int NS = Q_W;

	logic             vld_s1, vld_s2, vld_s3;
	q30_t             v_s1 [3], v_s2 [3], v_s3 [3];
	logic [P_W-1:0]   sq_s2 [3];
	logic [P_W-1:0]   sum_s3;
	tag_t             tag_s1, tag_s2, tag_s3;

	logic [P_W-1:0]   rem_s [1:NS];
	logic [P_W-1:0]   res_s [1:NS];
	q30_t             vr_s  [1:NS][3];
	tag_t             tr_s  [1:NS];
	logic             vv_s  [1:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// lane 0 is longitude (a1), lane 1 latitude (a2)
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= qmul(cs[0], cs[1]);
			v_s1[1] <= qmul(cs[0], sn[1]);
			v_s1[2] <= qmul(sn[0], cs[1]);
			tag_s1  <= tag_in;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {{Q_W{1'b0}}, v_s1[i]} * {{Q_W{1'b0}}, v_s1[i]};
				v_s2[i]  <= v_s1[i];
				v_s3[i]  <= v_s2[i];
			end
			tag_s2 <= tag_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			tag_s3 <= tag_s2;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_rt
		localparam int SH = 2 * (NS - 1 - j);
		logic [P_W-1:0] rem_in, res_in, t;
		logic           take, vld_in;
		q30_t           v_in [3];
		tag_t           tag_in_j;

		if (j == 0) begin : g_first
			assign rem_in   = sum_s3;
			assign res_in   = '0;
			assign v_in     = v_s3;
			assign tag_in_j = tag_s3;
			assign vld_in   = vld_s3;
		end else begin : g_next
			assign rem_in   = rem_s[j];
			assign res_in   = res_s[j];
			assign v_in     = vr_s[j];
			assign tag_in_j = tr_s[j];
			assign vld_in   = vv_s[j];
		end

		assign t    = res_in + (P_W'(1) << SH);
		assign take = rem_in >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[j+1] <= 1'b0;
			end else if (en) begin
				vv_s[j+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? rem_in - t : rem_in;
				res_s[j+1] <= take ? (res_in >> 1) + (P_W'(1) << SH) : res_in >> 1;
				vr_s[j+1]  <= v_in;
				tr_s[j+1]  <= tag_in_j;
			end
		end
	end

	assign out_vld = vv_s[NS];
	assign vec     = vr_s[NS];
	assign norm    = res_s[NS][Q_W-1:0];
	assign tag_out = tr_s[NS];
endmodule

[design/csv_div.sv]
// Rounded division of each component by the norm, one quotient bit per stage,
// then limit, sign and the output register. Depends on csv_pkg.
`timescale 1ns / 1ps
module csv_div import csv_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  q30_t vec [3],
	input  q30_t norm,
	input  tag_t tag_in,
	output logic out_vld,
	output vec_t res [3],
	output logic index_error
);
	localparam int NQ = FRAC_BITS + 1;
	localparam int DW = Q_W + FRAC_BITS + 1;
	localparam int CW = (NQ > VEC_W) ? NQ : VEC_W;

	logic          vld_s0;
	logic [DW-1:0] rem_s0 [3];
	q30_t          nrm_s0;
	tag_t          tag_s0;

	logic [DW-1:0] rem_s [1:NQ][3];
	logic [NQ-1:0] quo_s [1:NQ][3];
	q30_t          nrm_s [1:NQ];
	tag_t          tag_s [1:NQ];
	logic          vld_s [1:NQ];

	vec_t          res_sf [3];
	logic          err_sf;
	logic          vld_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_vld;
			vld_sf <= vld_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s0[i] <= (DW'(vec[i]) << FRAC_BITS) + DW'(norm >> 1);
			end
			nrm_s0 <= norm;
			tag_s0 <= tag_in;
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_dv
		localparam int K = NQ - 1 - j;
		logic [DW-1:0] rem_in [3];
		logic [NQ-1:0] quo_in [3];
		q30_t          nrm_in;
		tag_t          tag_in_j;
		logic          vld_in;
		logic [DW-1:0] dv;

		if (j == 0) begin : g_first
			assign rem_in   = rem_s0;
			assign quo_in   = '{default: '0};
			assign nrm_in   = nrm_s0;
			assign tag_in_j = tag_s0;
			assign vld_in   = vld_s0;
		end else begin : g_next
			assign rem_in   = rem_s[j];
			assign quo_in   = quo_s[j];
			assign nrm_in   = nrm_s[j];
			assign tag_in_j = tag_s[j];
			assign vld_in   = vld_s[j];
		end

		assign dv = DW'(nrm_in) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= dv) begin
						rem_s[j+1][i]    <= rem_in[i] - dv;
						quo_s[j+1][i]    <= quo_in[i] | (NQ'(1) << K);
					end else begin
						rem_s[j+1][i]    <= rem_in[i];
						quo_s[j+1][i]    <= quo_in[i];
					end
				end
				nrm_s[j+1] <= nrm_in;
				tag_s[j+1] <= tag_in_j;
			end
		end
	end

	logic [CW-1:0] qe [3];
	vec_t          mag [3];
	logic          neg [3];
	logic          kill;

	always_comb begin
		neg[0] = 1'b0;
		neg[1] = tag_s[NQ].neg_y;
		neg[2] = tag_s[NQ].neg_z;
		kill   = tag_s[NQ].err || (nrm_s[NQ] == '0);
		for (int i = 0; i < 3; i++) begin
			qe[i] = CW'(quo_s[NQ][i]);
			if (qe[i] > (CW'(1) << FRAC_BITS)) qe[i] = CW'(1) << FRAC_BITS;
			if (qe[i] > CW'(VEC_MAX)) qe[i] = CW'(VEC_MAX);
			mag[i] = vec_t'(qe[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (kill) begin
					res_sf[i] <= '0;
				end else begin
					res_sf[i] <= neg[i] ? -mag[i] : mag[i];
				end
			end
			err_sf <= tag_s[NQ].err;
		end
	end

	assign out_vld     = vld_sf;
	assign res         = res_sf;
	assign index_error = err_sf;
endmodule

[design/cube_sphere_vertex_generator.sv]
// Top level of the cube-sphere face vertex generator.
// Depends on csv_pkg, csv_if, csv_angle, csv_trig, csv_norm, csv_div and the assert header.
`timescale 1ns / 1ps
// Maps a (row, col) position on one cube face grid of 2^level+1 points per side to a
// unit direction in signed fixed point with FRAC_BITS fraction bits. One request is
// taken per clock while no result is stalled. The pipe has 2 angle stages, 6 sine/cosine
// stages, 3 product stages, 31 square-root stages (one root bit each), a divider setup stage,
// 1 + FRAC_BITS divider stages (one quotient bit each) and the output register.
// A stalled result stops the whole pipe. Out-of-range indices
// return a zero vector with index_error set. The level register may be written only
// while no request is in flight; values outside 1..8 are clamped.
`include "cube_sphere_vertex_generator_assert.svh"
module cube_sphere_vertex_generator import csv_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input logic         clk,
	input logic         arst_n,
	csv_cfg_if.sink     cfg,
	csv_in_if.sink      grid,
	csv_out_if.source   vertex
);
	lvl_t lvl_q;
	logic en;

	logic a_vld, t_vld, n_vld;
	q30_t ang [2];
	q30_t sn [2], cs [2];
	q30_t vec [3];
	q30_t norm;
	tag_t a_tag, t_tag, n_tag;
	vec_t res [3];

	assign en         = !vertex.valid || vertex.ready;
	assign grid.ready = en;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= LVL_RESET;
		end else if (cfg.valid) begin
			lvl_q <= cfg.subdivision_level;
		end
	end

	csv_angle u_angle (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (grid.valid),
		.row     (grid.row_index),
		.col     (grid.col_index),
		.lvl     (lvl_q),
		.out_vld (a_vld),
		.ang     (ang),
		.tag     (a_tag)
	);

	csv_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (a_vld),
		.ang     (ang),
		.tag_in  (a_tag),
		.out_vld (t_vld),
		.sn      (sn),
		.cs      (cs),
		.tag_out (t_tag)
	);

	csv_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (t_vld),
		.sn      (sn),
		.cs      (cs),
		.tag_in  (t_tag),
		.out_vld (n_vld),
		.vec     (vec),
		.norm    (norm),
		.tag_out (n_tag)
	);

	csv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (n_vld),
		.vec         (vec),
		.norm        (norm),
		.tag_in      (n_tag),
		.out_vld     (vertex.valid),
		.res         (res),
		.index_error (vertex.index_error)
	);

	assign vertex.vec_x = res[0];
	assign vertex.vec_y = res[1];
	assign vertex.vec_z = res[2];

	`CSV_ASSERT(a_err_zero, clk, arst_n, vertex.valid && vertex.index_error |-> vertex.vec_x == '0 && vertex.vec_y == '0 && vertex.vec_z == '0)
	`CSV_ASSERT(a_x_pos, clk, arst_n, vertex.valid && !vertex.index_error |-> !vertex.vec_x[VEC_W-1] && vertex.vec_x != '0)
	`CSV_ASSERT(a_stall_blocks, clk, arst_n, vertex.valid && !vertex.ready |-> !grid.ready)
	`CSV_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !vertex.valid)
endmodule
